/* rtl/core/smx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine package
// Shared widths, opcodes, status codes and channel payload types.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int NUM_REGS_DEF    = 9;
   localparam int WORD_W          = 32;
   localparam int ARG_W           = 8;
   localparam int DEPTH_W         = 7;

   typedef enum logic [2:0] {
      OP_PUSH_REG = 3'd0,
      OP_PUSH_IMM = 3'd1,
      OP_POP_REG  = 3'd2,
      OP_ADD      = 3'd3,
      OP_SUB      = 3'd4,
      OP_MUL      = 3'd5,
      OP_HALT     = 3'd6,
      OP_NOP      = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_HALT   = 3'd1,
      ST_UNDER  = 3'd2,
      ST_OVER   = 3'd3,
      ST_BADREG = 3'd4
   } status_type;

   typedef struct packed {
      logic              [2:0] op;
      logic signed [ARG_W-1:0] arg;
   } req_type;

   typedef struct packed {
      logic               [2:0] status;
      logic signed [WORD_W-1:0] moved_value;
      logic signed [WORD_W-1:0] top_value;
      logic       [DEPTH_W-1:0] depth;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

/* rtl/core/smx_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences capture and execution of one instruction and owns the handshakes.
// ----------------------------------------------------------------------------
module smx_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smx_pkg::cmd_type cmd
);
   import smx_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      load;
   logic      exec;

   assign load      = req_valid && !req_stall_ff;
   assign exec      = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign cmd.load  = load;
   assign cmd.exec  = exec;
   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (load) begin
                  state_ff     <= S_EXEC;
                  req_stall_ff <= 1'b1;
               end
            end
            S_EXEC: begin
               if (exec) begin
                  state_ff     <= S_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* rtl/core/smx_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine datapath
// Register file, stack memory with cached top entry, ALU and result register.
// ----------------------------------------------------------------------------
module smx_dpath #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
   parameter int NUM_REGS    = smx_pkg::NUM_REGS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  smx_pkg::cmd_type cmd,
   input  smx_pkg::req_type req_data,
   output smx_pkg::rsp_type rsp_data
);
   import smx_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam logic [ARG_W-1:0] NREGS_ARG = ARG_W'(NUM_REGS);
   localparam logic [CW-1:0]    FULL_CNT  = CW'(STACK_DEPTH);

   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0] reg_mem   [NUM_REGS];
   logic [NUM_REGS-1:0] reg_vld_ff;

   logic [2:0]        op_ff;
   logic [ARG_W-1:0]  arg_ff;
   logic [WORD_W-1:0] next_rd_ff;
   logic [WORD_W-1:0] reg_rd_ff;
   logic              reg_rd_vld_ff;
   logic [WORD_W-1:0] top_ff;
   logic [WORD_W-1:0] top_in;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [RW-1:0]     req_idx;
   logic [RW-1:0]     cur_idx;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic              reg_ok;
   logic              empty;
   logic              full;
   logic              two;
   logic [WORD_W-1:0] reg_val;
   logic [WORD_W-1:0] imm_val;
   logic [WORD_W-1:0] product;
   logic [WORD_W-1:0] moved;
   status_type        status;
   logic              stack_we;
   logic              reg_we;

   assign req_idx = req_data.arg[RW-1:0];
   assign cur_idx = arg_ff[RW-1:0];
   assign rd_addr = AW'(count_ff - CW'(2));
   assign wr_addr = AW'(count_ff - CW'(1));
   assign reg_ok  = !arg_ff[ARG_W-1] && ({1'b0, arg_ff[ARG_W-2:0]} < NREGS_ARG);
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign two     = (count_ff >= CW'(2));
   assign reg_val = reg_rd_vld_ff ? reg_rd_ff : '0;
   assign imm_val = {{(WORD_W-ARG_W){arg_ff[ARG_W-1]}}, arg_ff};
   assign product = top_ff * next_rd_ff;

   always_comb begin
      status   = ST_OK;
      moved    = '0;
      top_in   = top_ff;
      count_in = count_ff;
      stack_we = 1'b0;
      reg_we   = 1'b0;
      case (op_ff)
         OP_PUSH_REG, OP_PUSH_IMM: begin
            if ((op_ff == OP_PUSH_REG) && !reg_ok) begin
               status = ST_BADREG;
            end else if (full) begin
               status = ST_OVER;
            end else begin
               moved    = (op_ff == OP_PUSH_REG) ? reg_val : imm_val;
               top_in   = moved;
               count_in = count_ff + CW'(1);
               stack_we = !empty;
            end
         end
         OP_POP_REG: begin
            if (!reg_ok) begin
               status = ST_BADREG;
            end else if (empty) begin
               status = ST_UNDER;
            end else begin
               moved    = top_ff;
               top_in   = two ? next_rd_ff : '0;
               count_in = count_ff - CW'(1);
               reg_we   = 1'b1;
            end
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            if (!two) begin
               status = ST_UNDER;
            end else begin
               case (op_ff)
                  OP_ADD:  moved = top_ff + next_rd_ff;
                  OP_SUB:  moved = top_ff - next_rd_ff;
                  default: moved = product;
               endcase
               top_in   = moved;
               count_in = count_ff - CW'(1);
            end
         end
         OP_HALT: begin
            status = ST_HALT;
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_in.status      = status;
      rsp_in.moved_value = moved;
      rsp_in.top_value   = top_in;
      rsp_in.depth       = DEPTH_W'(count_in);
   end

   assign rsp_data = rsp_ff;

   // stack memory: entries below the cached top
   always_ff @(posedge clock) begin
      next_rd_ff <= stack_mem[rd_addr];
      if (cmd.exec && stack_we) begin
         stack_mem[wr_addr] <= top_ff;
      end
   end

   // register file memory
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         reg_rd_ff <= reg_mem[req_idx];
      end
      if (cmd.exec && reg_we) begin
         reg_mem[cur_idx] <= moved;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff    <= '0;
         reg_rd_vld_ff <= 1'b0;
         top_ff        <= '0;
         count_ff      <= '0;
      end else begin
         if (cmd.load) begin
            reg_rd_vld_ff <= reg_vld_ff[req_idx];
         end
         if (cmd.exec) begin
            top_ff   <= top_in;
            count_ff <= count_in;
            if (reg_we) begin
               reg_vld_ff[cur_idx] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.op;
         arg_ff <= req_data.arg;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* rtl/core/stack_machine_execute.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute
// Executes one stack-machine instruction per request transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction (op, arg); rsp_* returns one result for
//   each: status, moved value, new top of stack and depth.
//   Both channels transfer when valid is high and stall is low.
//   An instruction is captured on request transfer, when the register file
//   and the stack entry below the top are read; it executes in the next cycle
//   unless the result register is still full. Requests do not overlap:
//   req_stall stays high from capture until execute, set by the registered
//   read of the stack memory ahead of the read-modify-write of the top.
//   A new request is taken while the previous result still waits; the
//   instruction then holds in execute until the result register frees.
//   Reset marks the registers invalid, so they read as zero, and empties the
//   stack; the stack memory is not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module stack_machine_execute #(
   parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
   parameter int NUM_REGS    = smx_pkg::NUM_REGS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smx_pkg::rsp_type rsp_data
);
   import smx_pkg::*;

   cmd_type cmd;

   smx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   smx_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_REGS    (NUM_REGS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
